>>> sv/swf_pkg.sv
// Shared constants, types and the stop word table of the stop word filter.
package swf_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned WORD_MAX_DEF = 19;
  localparam byte_t       CH_SPACE     = 8'h20;
  localparam byte_t       CH_NEWLINE   = 8'h0A;

  localparam int unsigned STOP_NUM  = 9;
  localparam int unsigned STOP_CHARS = 3;

  typedef byte_t [STOP_CHARS-1:0] stop_text_t;

  // Characters are stored with index 0 in the low byte.
  localparam stop_text_t STOP_TEXT [STOP_NUM] = '{
    {8'h65, 8'h68, 8'h74},  // the
    {8'h00, 8'h00, 8'h61},  // a
    {8'h00, 8'h6E, 8'h61},  // an
    {8'h00, 8'h66, 8'h6F},  // of
    {8'h72, 8'h6F, 8'h66},  // for
    {8'h00, 8'h6F, 8'h74},  // to
    {8'h64, 8'h6E, 8'h61},  // and
    {8'h74, 8'h75, 8'h62},  // but
    {8'h74, 8'h65, 8'h79}   // yet
  };

  localparam logic [1:0] STOP_LEN [STOP_NUM] = '{
    2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3
  };

endpackage

>>> sv/swf_in_if.sv
// Input channel of the stop word filter: one text byte or end marker per beat.
interface swf_in_if;
  logic              valid;
  logic              ready;
  swf_pkg::byte_t    text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> sv/swf_out_if.sv
// Output channel of the stop word filter: one filtered byte per beat.
interface swf_out_if;
  logic              valid;
  logic              ready;
  swf_pkg::byte_t    out_byte;
  logic              run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

>>> sv/swf_stop_match.sv
// Compares the buffered word against the fixed stop word table.
module swf_stop_match #(
  parameter int unsigned LW = 5
) (
  input  logic [LW-1:0]        len_i,
  input  swf_pkg::stop_text_t  chars_i,
  output logic                 stop_o
);
  import swf_pkg::*;

  logic [STOP_NUM-1:0] hit;

  always_comb begin
    for (int s = 0; s < STOP_NUM; s++) begin
      hit[s] = (len_i == LW'(STOP_LEN[s])) &&
               (chars_i[0] == STOP_TEXT[s][0]) &&
               ((STOP_LEN[s] < 2'd2) || (chars_i[1] == STOP_TEXT[s][1])) &&
               ((STOP_LEN[s] < 2'd3) || (chars_i[2] == STOP_TEXT[s][2]));
    end
  end

  assign stop_o = |hit;

endmodule

>>> sv/swf_word_mem.sv
// Word buffer memory with one write port and one registered read port.
module swf_word_mem #(
  parameter int unsigned WORD_MAX = swf_pkg::WORD_MAX_DEF,
  parameter int unsigned AW       = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  swf_pkg::byte_t  wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output swf_pkg::byte_t  rdata_o
);
  import swf_pkg::*;

  byte_t mem_q [WORD_MAX];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/stop_word_filter.sv
// Top level of the stop word filter: word buffer, sequencer and output register.
//
// Bytes arrive on in_i and filtered bytes leave on out_o, both valid/ready.
// A plain byte is written into the word buffer while it has room. A space, a
// newline or an end marker closing an open line flushes the buffered word:
// unless it is a stop word, it is sent byte by byte, each by a buffer read
// and then a load into the output register, preceded by a space when a
// word was already sent on the line. A newline, or an end marker on an open
// line, then sends a newline. run_last marks the final beat caused by one
// input beat. in_i.ready is high only while the sequencer is idle, so a new
// input beat is taken only once the last one's output beats are loaded.
// The output register lets a new input beat be taken while a result waits.
// When out_o.ready is low the sequencer holds its position and loses
// nothing. Reset empties the word buffer and the line state and clears the
// output valid flag; the block comes out of reset idle and ready.
module stop_word_filter #(
  parameter int unsigned WORD_MAX = swf_pkg::WORD_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swf_in_if.sink    in_i,
  swf_out_if.source out_o
);
  import swf_pkg::*;

  localparam int unsigned AW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int unsigned LW = $clog2(WORD_MAX + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SPACE = 5'b00010,
    ST_READ  = 5'b00100,
    ST_BYTE  = 5'b01000,
    ST_NEWL  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] emit_len_q, emit_len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          nl_q, nl_d;
  logic          lhw_q, lhw_d;
  logic          open_q, open_d;
  stop_text_t    head_q;
  logic          out_valid_q, out_valid_d;
  byte_t         out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic  accept, can_load, is_nl, is_sp, ends_word, stop, do_nl, do_flush, last_byte;
  logic  we, re;
  byte_t rdata;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign accept         = in_i.valid && in_i.ready;
  assign can_load       = !out_valid_q || out_o.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_last = out_last_q;

  assign is_nl     = !in_i.end_of_text && (in_i.text_byte == CH_NEWLINE);
  assign is_sp     = !in_i.end_of_text && (in_i.text_byte == CH_SPACE);
  assign do_nl     = in_i.end_of_text ? open_q : is_nl;
  assign ends_word = do_nl || is_sp;
  assign do_flush  = ends_word && (len_q != '0) && !stop;
  assign we        = accept && !in_i.end_of_text && !is_nl && !is_sp &&
                     (len_q < LW'(WORD_MAX));
  assign re        = (state_q == ST_READ);
  assign last_byte = (LW'(idx_q) == (emit_len_q - LW'(1)));

  swf_stop_match #(
    .LW(LW)
  ) u_match (
    .len_i  (len_q),
    .chars_i(head_q),
    .stop_o (stop)
  );

  swf_word_mem #(
    .WORD_MAX(WORD_MAX),
    .AW      (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(in_i.text_byte),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    emit_len_d  = emit_len_q;
    idx_d       = idx_q;
    nl_d        = nl_q;
    lhw_d       = lhw_q;
    open_d      = open_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d      = '0;
          nl_d       = do_nl;
          emit_len_d = len_q;
          if (we) begin
            len_d = len_q + LW'(1);
          end
          if (!in_i.end_of_text) begin
            open_d = 1'b1;
          end
          if (ends_word) begin
            len_d = '0;
          end
          if (do_flush) begin
            lhw_d   = 1'b1;
            state_d = lhw_q ? ST_SPACE : ST_READ;
          end else if (do_nl) begin
            state_d = ST_NEWL;
          end
          if (do_nl) begin
            lhw_d  = 1'b0;
            open_d = 1'b0;
          end
        end
      end
      ST_SPACE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = CH_SPACE;
          out_last_d  = 1'b0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_BYTE;
      end
      ST_BYTE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata;
          out_last_d  = last_byte && !nl_q;
          idx_d       = idx_q + AW'(1);
          if (!last_byte) begin
            state_d = ST_READ;
          end else begin
            state_d = nl_q ? ST_NEWL : ST_IDLE;
          end
        end
      end
      ST_NEWL: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_byte_d  = CH_NEWLINE;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      lhw_q       <= 1'b0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      lhw_q       <= lhw_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_len_q <= emit_len_d;
    idx_q      <= idx_d;
    nl_q       <= nl_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (we && (len_q == LW'(0))) begin
      head_q[0] <= in_i.text_byte;
    end
    if (we && (len_q == LW'(1))) begin
      head_q[1] <= in_i.text_byte;
    end
    if (we && (len_q == LW'(2))) begin
      head_q[2] <= in_i.text_byte;
    end
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the stop word filter: directed and random text under random handshakes.
`timescale 1ns / 100ps
module tb;
  import swf_pkg::*;

  localparam int unsigned WORD_MAX     = WORD_MAX_DEF;
  localparam int unsigned TABLE_ROWS   = 17;
  localparam int unsigned RAND_ITEMS   = 500;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
  } out_beat_t;

  typedef struct {
    byte_t text_byte;
    logic  end_of_text;
    bit    typed;
    string want;
  } text_row_t;

  logic clk_i;
  logic rst_ni;

  swf_in_if  text_ch ();
  swf_out_if filt_ch ();

  stop_word_filter #(
    .WORD_MAX (WORD_MAX)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_ch),
    .out_o  (filt_ch)
  );

  string stop_words [9] = '{"the", "a", "an", "of", "for", "to", "and", "but", "yet"};

  text_row_t text_table [TABLE_ROWS] = '{
    '{8'h00,      1'b1, 1'b1, ""},
    '{CH_NEWLINE, 1'b0, 1'b1, "\n"},
    '{8'h00,      1'b0, 1'b1, ""},
    '{8'hFF,      1'b0, 1'b1, ""},
    '{CH_SPACE,   1'b0, 1'b0, ""},
    '{CH_SPACE,   1'b0, 1'b1, ""},
    '{"t",        1'b0, 1'b1, ""},
    '{"h",        1'b0, 1'b1, ""},
    '{"e",        1'b0, 1'b1, ""},
    '{CH_SPACE,   1'b0, 1'b1, ""},
    '{"T",        1'b0, 1'b1, ""},
    '{"h",        1'b0, 1'b1, ""},
    '{"e",        1'b0, 1'b1, ""},
    '{CH_NEWLINE, 1'b0, 1'b0, ""},
    '{"a",        1'b0, 1'b1, ""},
    '{8'hFF,      1'b1, 1'b1, "\n"},
    '{8'h00,      1'b1, 1'b1, ""}
  };

  byte_t       word_buf [WORD_MAX];
  int unsigned word_len      = 0;
  bit          line_has_word = 1'b0;
  bit          line_open     = 1'b0;

  out_beat_t   step_beats [$];
  out_beat_t   filtered_q [$];

  int unsigned err_count     = 0;
  int unsigned beats_in      = 0;
  int unsigned beats_out     = 0;
  int unsigned items_used    = 0;
  int unsigned words_kept    = 0;
  int unsigned words_dropped = 0;
  int unsigned bytes_cut     = 0;
  int unsigned idle_cycles   = 0;
  bit          hold_req      = 1'b0;
  bit          no_idle       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    err_count++;
  endtask

  function automatic void emit_byte(input byte_t b);
    step_beats.push_back('{out_byte: b, run_last: 1'b0});
  endfunction

  function automatic bit word_is_stop();
    bit same;
    foreach (stop_words[s]) begin
      if (stop_words[s].len() == word_len) begin
        same = 1'b1;
        for (int k = 0; k < word_len; k++)
          if (word_buf[k] != byte_t'(stop_words[s][k])) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void flush_word();
    if (word_len != 0) begin
      if (word_is_stop()) begin
        words_dropped++;
      end else begin
        if (line_has_word) emit_byte(CH_SPACE);
        for (int k = 0; k < word_len; k++) emit_byte(word_buf[k]);
        line_has_word = 1'b1;
        words_kept++;
      end
    end
    word_len = 0;
  endfunction

  function automatic void close_line();
    flush_word();
    emit_byte(CH_NEWLINE);
    line_has_word = 1'b0;
    line_open     = 1'b0;
  endfunction

  // Works out the filtered bytes that one accepted text beat causes.
  function automatic void filter_text(input byte_t b, input logic eot);
    step_beats.delete();
    if (eot) begin
      if (line_open) close_line();
    end else if (b == CH_NEWLINE) begin
      close_line();
    end else if (b == CH_SPACE) begin
      flush_word();
      line_open = 1'b1;
    end else begin
      if (word_len < WORD_MAX) begin
        word_buf[word_len] = b;
        word_len++;
      end else begin
        bytes_cut++;
      end
      line_open = 1'b1;
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
  endfunction

  task automatic send_beat(input byte_t b, input logic eot, input bit typed = 1'b0,
                           input string want = "");
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.end_of_text <= eot;
    @(posedge clk_i);
    while (!text_ch.ready) @(posedge clk_i);
    beats_in++;
    if (!eot || line_open) items_used++;
    filter_text(b, eot);
    if (typed) begin
      for (int k = 0; k < want.len(); k++)
        filtered_q.push_back('{out_byte: byte_t'(want[k]), run_last: (k == want.len() - 1)});
    end else begin
      foreach (step_beats[k]) filtered_q.push_back(step_beats[k]);
    end
  endtask

  function automatic byte_t rand_word_byte();
    byte_t c;
    case ($urandom_range(0, 3))
      0: begin
        do c = byte_t'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_NEWLINE);
      end
      default: c = byte_t'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  task automatic send_delimiter();
    int unsigned d;
    d = $urandom_range(0, 9);
    if (d < 7) send_beat(CH_SPACE, 1'b0);
    else if (d < 9) send_beat(CH_NEWLINE, 1'b0);
    else send_beat(byte_t'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : text_source
    int unsigned kind, len, pick, flip;
    bit          held, paused;
    held   = 1'b0;
    paused = 1'b0;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= '0;
    text_ch.end_of_text <= 1'b0;
    rst_ni              <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (text_table[r])
      send_beat(text_table[r].text_byte, text_table[r].end_of_text, text_table[r].typed,
                text_table[r].want);

    // Mostly words and stop words with delimiters, mixed with raw noise.
    while (items_used < TABLE_ROWS + RAND_ITEMS) begin
      no_idle = hold_req || (items_used >= 80 && items_used < 150);
      if (!held && items_used >= 220) begin
        held     = 1'b1;
        hold_req = 1'b1;
        no_idle  = 1'b1;
      end
      if (!paused && items_used >= 380) begin
        paused = 1'b1;
        text_ch.valid <= 1'b0;
        wait (filtered_q.size() == 0);
        @(posedge clk_i);
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        pick = $urandom_range(0, 8);
        flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, stop_words[pick].len() - 1) : 99;
        for (int k = 0; k < stop_words[pick].len(); k++)
          send_beat(byte_t'(stop_words[pick][k]) ^ ((k == flip) ? 8'h20 : 8'h00), 1'b0);
        if ($urandom_range(0, 7) == 0) send_beat(rand_word_byte(), 1'b0);
        send_delimiter();
      end else if (kind < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(WORD_MAX - 4, WORD_MAX + 5)
                                          : $urandom_range(1, 6);
        repeat (len) send_beat(rand_word_byte(), 1'b0);
        send_delimiter();
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3)) send_delimiter();
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(byte_t'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
    end

    text_ch.valid <= 1'b0;
    wait (filtered_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d text beats (%0d effective) and checked %0d filtered beats.",
             beats_in, items_used, beats_out);
    $display("Words passed: %0d, stop words removed: %0d, bytes cut from long words: %0d.",
             words_kept, words_dropped, bytes_cut);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    filt_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        filt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        filt_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      filt_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!filt_ch.valid);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni) begin
      if (filt_ch.valid && filt_ch.ready) begin
        beats_out++;
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, byte %h", filt_ch.out_byte));
        end else begin
          want = filtered_q.pop_front();
          if (filt_ch.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, wanted %h", filt_ch.out_byte,
                                      want.out_byte));
          if (filt_ch.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, wanted %b on byte %h", filt_ch.run_last,
                                      want.run_last, want.out_byte));
        end
      end
      if ((filt_ch.valid && filt_ch.ready) || (text_ch.valid && text_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
                   STALL_LIMIT, filtered_q.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

endmodule
